[design/spm_pkg.sv]
// Shared types, constants and saturating helpers of the sparse polynomial multiplier.
// Used by every other file of the block; depends on nothing.
package spm_pkg;

  localparam int INPUT_TERMS_DEF   = 32;
  localparam int PRODUCT_TERMS_DEF = 64;

  localparam logic [1:0] KIND_LOAD_FIRST  = 2'd0;
  localparam logic [1:0] KIND_LOAD_SECOND = 2'd1;
  localparam logic [1:0] KIND_COMPUTE     = 2'd2;

  localparam logic CFG_IDX_MODE  = 1'b0;
  localparam logic CFG_IDX_POWER = 1'b1;

  localparam logic MODE_MULTIPLY = 1'b0;

  typedef struct packed {
    logic               valid;
    logic signed [31:0] coef;
    logic signed [15:0] expo;
  } term_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_INSERT,
    OP_ROTATE,
    OP_SHIFT,
    OP_CLEAR,
    OP_LOAD
  } chain_op_t;

  typedef struct packed {
    chain_op_t          op;
    logic               shift_ok;
    logic signed [31:0] coef;
    logic signed [15:0] expo;
  } chain_cmd_t;

  function automatic logic signed [31:0] sat_add32(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      sat_add32 = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      sat_add32 = s[31:0];
    end
  endfunction

  function automatic logic signed [15:0] sat_exp(input logic signed [16:0] s);
    if (s[16] != s[15]) begin
      sat_exp = s[16] ? 16'sh8000 : 16'sh7FFF;
    end else begin
      sat_exp = s[15:0];
    end
  endfunction

  function automatic logic signed [31:0] sat_coef(input logic signed [47:0] q);
    if ((q[47:31] != 17'h0) && (q[47:31] != 17'h1FFFF)) begin
      sat_coef = q[47] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      sat_coef = q[31:0];
    end
  endfunction

endpackage

[design/sparse_polynomial_multiplier.sv]
// Sparse polynomial multiplier top level: control sequencer, term chains and output register.
// Depends on spm_pkg, spm_chain (with spm_cell) and spm_mul.
//
// Terms are loaded one per transfer: the target chain compares the new
// exponent in every cell at once, merges a like term or opens a gap and
// shifts the lower terms one cell along. A compute transfer then multiplies
// every pair of operand terms in multiply mode; in power mode it first
// copies the first operand into the product chain, and each power step
// then copies the product into the scratch chain and multiplies it by the
// first operand. The single multiplier takes one term pair per cycle while
// the operand chains rotate past their heads, and the product chain absorbs
// one product term per cycle; the two multiplier stages are drained after
// each pass. The result is then emitted one term per cycle from the top of
// the product chain, highest exponent first, for as long as the output side
// does not stall. No input is taken from the compute transfer until its
// last result has moved into the output register; configuration is meant
// to be written only while the block is idle.
module sparse_polynomial_multiplier import spm_pkg::*; #(
  parameter int INPUT_TERMS   = INPUT_TERMS_DEF,
  parameter int PRODUCT_TERMS = PRODUCT_TERMS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         kind,
  input  logic signed [31:0] term_coefficient,
  input  logic signed [15:0] term_exponent,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_coefficient,
  output logic signed [15:0] out_exponent,
  output logic               capacity_overflow,
  output logic               empty_result,
  output logic               last_term,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [4:0]         cfg_data
);

  localparam int FW   = $clog2(INPUT_TERMS + 1);
  localparam int PW   = $clog2(PRODUCT_TERMS + 1);
  localparam int MAXT = (INPUT_TERMS > PRODUCT_TERMS) ? INPUT_TERMS : PRODUCT_TERMS;
  localparam int CW   = $clog2(MAXT + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_COPY,
    S_MUL,
    S_DRAIN,
    S_EMIT,
    S_EMPTY
  } state_t;

  state_t     state;
  logic       mode;
  logic [4:0] power_degree;
  logic       overflow_seen;
  logic       use_scratch;
  logic [3:0] steps;
  logic [CW-1:0] outer_idx;
  logic [CW-1:0] inner_idx;

  // Chain signals
  chain_op_t first_op, second_op, product_op, scratch_op;
  logic signed [31:0] first_xc, product_xc;
  logic signed [15:0] first_xe, product_xe;
  term_t first_cells [INPUT_TERMS];
  term_t second_cells [INPUT_TERMS];
  term_t product_cells [PRODUCT_TERMS];
  term_t scratch_cells [PRODUCT_TERMS];
  term_t no_load_in [INPUT_TERMS];
  term_t first_head, second_head, product_head, scratch_head;
  logic [FW-1:0] first_count, second_count;
  logic [PW-1:0] product_count, scratch_count;
  logic first_drop, second_drop, product_drop, scratch_drop;

  // Multiplier signals
  logic  mul_in_valid, mul_valid, mul_busy;
  term_t mul_a, mul_b, mul_res;

  logic          in_xfer;
  logic          out_free;
  logic          out_load;
  logic [CW-1:0] outer_count, inner_count;
  logic          inner_wrap, outer_done;
  logic          operands_empty;
  logic [4:0]    power_clamped;

  for (genvar i = 0; i < INPUT_TERMS; i++) begin : g_noload
    assign no_load_in[i] = '0;
  end

  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign out_load = out_free && ((state == S_EMIT) || (state == S_EMPTY));

  assign outer_count = use_scratch ? CW'(scratch_count) : CW'(first_count);
  assign inner_count = use_scratch ? CW'(first_count) : CW'(second_count);
  assign inner_wrap  = (inner_idx + 1'b1 == inner_count);
  assign outer_done  = inner_wrap && (outer_idx + 1'b1 == outer_count);

  assign operands_empty = (first_count == '0) ||
                          ((mode == MODE_MULTIPLY) && (second_count == '0));
  assign power_clamped  = (power_degree == 5'd0) ? 5'd1 :
                          ((power_degree > 5'd16) ? 5'd16 : power_degree);

  assign mul_in_valid = (state == S_MUL);
  assign mul_a        = use_scratch ? scratch_head : first_head;
  assign mul_b        = use_scratch ? first_head : second_head;

  // Chain operation selection.
  always_comb begin
    first_op   = OP_NOP;
    second_op  = OP_NOP;
    product_op = OP_NOP;
    scratch_op = OP_NOP;
    first_xc   = term_coefficient;
    first_xe   = term_exponent;
    product_xc = mul_res.coef;
    product_xe = mul_res.expo;

    unique case (state)
      S_IDLE: begin
        if (in_xfer && (kind == KIND_LOAD_FIRST)) first_op = OP_INSERT;
        if (in_xfer && (kind == KIND_LOAD_SECOND)) second_op = OP_INSERT;
      end
      S_INIT: begin
        first_op   = OP_ROTATE;
        product_op = OP_INSERT;
        product_xc = first_head.coef;
        product_xe = first_head.expo;
      end
      S_COPY: begin
        scratch_op = OP_LOAD;
        product_op = OP_CLEAR;
      end
      S_MUL: begin
        if (use_scratch) begin
          first_op = OP_ROTATE;
          if (inner_wrap) scratch_op = OP_ROTATE;
        end else begin
          second_op = OP_ROTATE;
          if (inner_wrap) first_op = OP_ROTATE;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          product_op = OP_SHIFT;
          if (product_count == PW'(1)) begin
            first_op  = OP_CLEAR;
            second_op = OP_CLEAR;
          end
        end
      end
      S_EMPTY: begin
        if (out_free) begin
          first_op  = OP_CLEAR;
          second_op = OP_CLEAR;
        end
      end
      default: ;
    endcase

    // Product terms arriving from the multiplier drain while the next pair issues.
    if (mul_valid) product_op = OP_INSERT;
  end

  spm_chain #(.DEPTH(INPUT_TERMS)) u_first (
    .clk        (clk),
    .rst        (rst),
    .op         (first_op),
    .x_coef     (first_xc),
    .x_expo     (first_xe),
    .load_cells (no_load_in),
    .load_count ('0),
    .cells      (first_cells),
    .head       (first_head),
    .count      (first_count),
    .drop       (first_drop)
  );

  spm_chain #(.DEPTH(INPUT_TERMS)) u_second (
    .clk        (clk),
    .rst        (rst),
    .op         (second_op),
    .x_coef     (term_coefficient),
    .x_expo     (term_exponent),
    .load_cells (no_load_in),
    .load_count ('0),
    .cells      (second_cells),
    .head       (second_head),
    .count      (second_count),
    .drop       (second_drop)
  );

  spm_chain #(.DEPTH(PRODUCT_TERMS)) u_product (
    .clk        (clk),
    .rst        (rst),
    .op         (product_op),
    .x_coef     (product_xc),
    .x_expo     (product_xe),
    .load_cells (scratch_cells),
    .load_count ('0),
    .cells      (product_cells),
    .head       (product_head),
    .count      (product_count),
    .drop       (product_drop)
  );

  spm_chain #(.DEPTH(PRODUCT_TERMS)) u_scratch (
    .clk        (clk),
    .rst        (rst),
    .op         (scratch_op),
    .x_coef     (product_xc),
    .x_expo     (product_xe),
    .load_cells (product_cells),
    .load_count (product_count),
    .cells      (scratch_cells),
    .head       (scratch_head),
    .count      (scratch_count),
    .drop       (scratch_drop)
  );

  spm_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mul_in_valid),
    .a         (mul_a),
    .b         (mul_b),
    .res_valid (mul_valid),
    .res       (mul_res),
    .busy      (mul_busy)
  );

  // Sequencer, configuration registers and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      mode          <= MODE_MULTIPLY;
      power_degree  <= 5'd2;
      overflow_seen <= 1'b0;
      use_scratch   <= 1'b0;
      steps         <= '0;
      outer_idx     <= '0;
      inner_idx     <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_IDX_MODE:  mode <= cfg_data[0];
          CFG_IDX_POWER: power_degree <= cfg_data;
          default: ;
        endcase
      end

      if (first_drop || second_drop || product_drop || scratch_drop) begin
        overflow_seen <= 1'b1;
      end

      // The output register takes a new term whenever it is free while a result
      // is being emitted, otherwise it empties once its term has been transferred.
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          outer_idx <= '0;
          inner_idx <= '0;
          if (in_xfer && (kind == KIND_COMPUTE)) begin
            if (operands_empty) begin
              state <= S_EMPTY;
            end else if (mode == MODE_MULTIPLY) begin
              use_scratch <= 1'b0;
              steps       <= '0;
              state       <= S_MUL;
            end else begin
              use_scratch <= 1'b1;
              steps       <= 4'(power_clamped - 5'd1);
              state       <= S_INIT;
            end
          end
        end
        S_INIT: begin
          outer_idx <= outer_idx + 1'b1;
          if (outer_idx + 1'b1 == CW'(first_count)) begin
            outer_idx <= '0;
            state     <= (steps == '0) ? S_EMIT : S_COPY;
          end
        end
        S_COPY: begin
          steps     <= steps - 1'b1;
          outer_idx <= '0;
          inner_idx <= '0;
          state     <= S_MUL;
        end
        S_MUL: begin
          if (inner_wrap) begin
            inner_idx <= '0;
            outer_idx <= outer_idx + 1'b1;
          end else begin
            inner_idx <= inner_idx + 1'b1;
          end
          if (outer_done) state <= S_DRAIN;
        end
        S_DRAIN: begin
          if (!mul_busy) state <= (steps == '0) ? S_EMIT : S_COPY;
        end
        S_EMIT: begin
          if (out_free) begin
            out_coefficient   <= product_head.coef;
            out_exponent      <= product_head.expo;
            capacity_overflow <= overflow_seen;
            empty_result      <= 1'b0;
            last_term         <= (product_count == PW'(1));
            if (product_count == PW'(1)) begin
              overflow_seen <= 1'b0;
              state         <= S_IDLE;
            end
          end
        end
        S_EMPTY: begin
          if (out_free) begin
            out_coefficient   <= '0;
            out_exponent      <= '0;
            capacity_overflow <= overflow_seen;
            empty_result      <= 1'b1;
            last_term         <= 1'b1;
            overflow_seen     <= 1'b0;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !mul_busy)
    else $error("multiplier still busy while the block is idle");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (product_count != '0))
    else $error("emission entered with an empty product chain");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_result |-> (out_coefficient == '0) && last_term)
    else $error("empty result carries a term");

endmodule

[design/spm_cell.sv]
// One cell of a sorted term chain: holds a single term and trades it with its neighbours.
// Depends on spm_pkg.
module spm_cell import spm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  chain_cmd_t cmd,
  input  logic       left_gt,
  input  term_t      left_term,
  input  term_t      right_term,
  input  term_t      head_term,
  input  term_t      load_term,
  output term_t      term,
  output logic       gt,
  output logic       eq
);

  term_t term_next;

  assign gt = term.valid && (term.expo > cmd.expo);
  assign eq = term.valid && (term.expo == cmd.expo);

  always_comb begin
    term_next = term;
    case (cmd.op)
      OP_INSERT: begin
        if (eq) begin
          term_next.coef = sat_add32(term.coef, cmd.coef);
        end else if (cmd.shift_ok && !gt) begin
          if (left_gt) begin
            term_next = '{valid: 1'b1, coef: cmd.coef, expo: cmd.expo};
          end else begin
            term_next = left_term;
          end
        end
      end
      OP_ROTATE: begin
        if (term.valid) begin
          term_next = right_term.valid ? right_term : head_term;
        end
      end
      OP_SHIFT:  term_next = right_term;
      OP_CLEAR:  term_next.valid = 1'b0;
      OP_LOAD:   term_next = load_term;
      default:   term_next = term;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      term.valid <= 1'b0;
    end else begin
      term <= term_next;
    end
  end

endmodule

[design/spm_chain.sv]
// A row of spm_cell kept sorted by descending exponent, with its term count.
// Depends on spm_pkg and spm_cell.
module spm_chain import spm_pkg::*; #(
  parameter int DEPTH = INPUT_TERMS_DEF,
  localparam int CNTW = $clog2(DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  chain_op_t          op,
  input  logic signed [31:0] x_coef,
  input  logic signed [15:0] x_expo,
  input  term_t              load_cells [DEPTH],
  input  logic [CNTW-1:0]    load_count,
  output term_t              cells [DEPTH],
  output term_t              head,
  output logic [CNTW-1:0]    count,
  output logic               drop
);

  logic [DEPTH-1:0] gts;
  logic [DEPTH-1:0] eqs;
  logic [DEPTH-1:0] valids;
  logic             any_eq;
  logic             full;
  chain_cmd_t       cmd;

  assign any_eq = |eqs;
  assign full   = (count == CNTW'(DEPTH));
  assign drop   = (op == OP_INSERT) && !any_eq && full;
  assign head   = cells[0];

  always_comb begin
    cmd.op       = op;
    cmd.shift_ok = !any_eq && !full;
    cmd.coef     = x_coef;
    cmd.expo     = x_expo;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    term_t left_term;
    term_t right_term;
    logic  left_gt;

    assign valids[i] = cells[i].valid;

    if (i == 0) begin : g_first
      assign left_gt   = 1'b1;
      assign left_term = '0;
    end else begin : g_mid
      assign left_gt   = gts[i-1];
      assign left_term = cells[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_term = '0;
    end else begin : g_inner
      assign right_term = cells[i+1];
    end

    spm_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .left_gt    (left_gt),
      .left_term  (left_term),
      .right_term (right_term),
      .head_term  (cells[0]),
      .load_term  (load_cells[i]),
      .term       (cells[i]),
      .gt         (gts[i]),
      .eq         (eqs[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (op)
        OP_INSERT: if (cmd.shift_ok) count <= count + 1'b1;
        OP_SHIFT:  if (count != '0) count <= count - 1'b1;
        OP_CLEAR:  count <= '0;
        OP_LOAD:   count <= load_count;
        default:   count <= count;
      endcase
    end
  end

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(valids) == count)
    else $error("chain count differs from the number of held terms");

  a_valid_prefix: assert property (@(posedge clk) disable iff (rst)
    ((valids >> 1) & ~valids) == '0)
    else $error("held terms do not form a prefix of the chain");

  a_sorted_head: assert property (@(posedge clk) disable iff (rst)
    (op == OP_INSERT) && !drop |=> (count == $past(count) + 1'b1) || $stable(count))
    else $error("insert changed the count by more than one");

endmodule

[design/spm_mul.sv]
// Two-stage coefficient multiplier with round-half-up and saturation, plus exponent sum.
// Depends on spm_pkg.
module spm_mul import spm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  term_t a,
  input  term_t b,
  output logic  res_valid,
  output term_t res,
  output logic  busy
);

  logic               v1;
  logic signed [63:0] prod;
  logic signed [16:0] esum;
  logic signed [63:0] rounded;

  assign rounded = prod + 64'sd32768;
  assign busy    = v1 || res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      res_valid <= v1;
    end
    prod     <= 64'(a.coef) * 64'(b.coef);
    esum     <= 17'(a.expo) + 17'(b.expo);
    res.valid <= 1'b1;
    res.coef <= sat_coef(rounded[63:16]);
    res.expo <= sat_exp(esum);
  end

endmodule

[test/tb_sparse_polynomial_multiplier.sv]
// Self-checking testbench for the sparse polynomial multiplier.
// Depends on spm_pkg and the sparse_polynomial_multiplier RTL; needs no files.
`timescale 1ns / 100ps

module tb_sparse_polynomial_multiplier;
  import spm_pkg::*;

  // Codes that the package does not name.
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic       MODE_POWER  = 1'b1;
  localparam int         ROW_ITEM    = 0;
  localparam int         ROW_REG     = 1;

  // Table slots of the predictor.
  localparam int TBL_FIRST   = 0;
  localparam int TBL_SECOND  = 1;
  localparam int TBL_PRODUCT = 2;
  localparam int TBL_SCRATCH = 3;
  localparam int IN_CAP      = 32;
  localparam int PROD_CAP    = 64;

  localparam int ITEM_TARGET = 360;
  localparam int QUIET_FROM  = 320;
  localparam int HOLD_FROM   = 120;

  typedef struct {
    logic signed [31:0] coef;
    logic signed [15:0] expo;
  } poly_term_t;

  typedef struct {
    logic signed [31:0] coef;
    logic signed [15:0] expo;
    logic               ovf;
    logic               empty;
    logic               last;
  } out_term_t;

  // One row of the directed part. A row with a typed result is a compute
  // whose single result can be read off directly.
  typedef struct {
    int                 row;
    logic [1:0]         kind;
    logic [31:0]        coef;
    logic [15:0]        expo;
    logic               reg_index;
    logic [4:0]         reg_data;
    bit                 typed;
    out_term_t          want;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         kind = KIND_LOAD_FIRST;
  logic signed [31:0] term_coefficient = '0;
  logic signed [15:0] term_exponent = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_coefficient;
  logic signed [15:0] out_exponent;
  logic               capacity_overflow;
  logic               empty_result;
  logic               last_term;
  logic               cfg_write = 1'b0;
  logic               cfg_index = CFG_IDX_MODE;
  logic [4:0]         cfg_data = '0;

  sparse_polynomial_multiplier dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state: the two operand tables, the product and its scratch copy.
  poly_term_t tbl [4][PROD_CAP];
  int         cnt [4];
  bit         ovf_seen;
  logic       cur_mode;
  logic [4:0] cur_power;

  out_term_t  pending_terms[$];
  int         errors;
  int         items_sent;
  bit         quiet;
  bit         hold_long;
  int         burst_left;

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [15:0] add_expo(logic signed [15:0] a,
                                                  logic signed [15:0] b);
    int s;
    s = int'(a) + int'(b);
    if (s > 32767) return 16'sh7FFF;
    if (s < -32768) return 16'sh8000;
    return s[15:0];
  endfunction

  // Q16.16 product, round half up, then saturate.
  function automatic logic signed [31:0] mul_coef(logic signed [31:0] a,
                                                  logic signed [31:0] b);
    longint r;
    r = longint'(a) * longint'(b) + 64'sh8000;
    r = r >>> 16;
    return clamp32(r);
  endfunction

  // Sorted insertion by descending exponent, merging like terms.
  function automatic void place_term(int t, int cap, logic signed [31:0] c,
                                     logic signed [15:0] e);
    int i;
    int k;
    i = 0;
    while (i < cnt[t] && tbl[t][i].expo > e) i++;
    if (i < cnt[t] && tbl[t][i].expo == e) begin
      tbl[t][i].coef = clamp32(longint'(tbl[t][i].coef) + longint'(c));
      return;
    end
    if (cnt[t] >= cap) begin
      ovf_seen = 1'b1;
      return;
    end
    for (k = cnt[t]; k > i; k--) tbl[t][k] = tbl[t][k-1];
    tbl[t][i].coef = c;
    tbl[t][i].expo = e;
    cnt[t]++;
  endfunction

  function automatic void multiply_tables(int ta, int na, int tb, int nb);
    cnt[TBL_PRODUCT] = 0;
    for (int i = 0; i < na; i++)
      for (int j = 0; j < nb; j++)
        place_term(TBL_PRODUCT, PROD_CAP, mul_coef(tbl[ta][i].coef, tbl[tb][j].coef),
                   add_expo(tbl[ta][i].expo, tbl[tb][j].expo));
  endfunction

  // Works out the results of a compute transfer and clears the tables.
  function automatic void predict_product();
    bit        none;
    int        p;
    int        n;
    out_term_t r;
    none = (cnt[TBL_FIRST] == 0) || (cur_mode == MODE_MULTIPLY && cnt[TBL_SECOND] == 0);
    if (!none) begin
      if (cur_mode == MODE_MULTIPLY) begin
        multiply_tables(TBL_FIRST, cnt[TBL_FIRST], TBL_SECOND, cnt[TBL_SECOND]);
      end else begin
        p = (cur_power < 1) ? 1 : ((cur_power > 16) ? 16 : int'(cur_power));
        cnt[TBL_PRODUCT] = 0;
        for (int k = 0; k < cnt[TBL_FIRST]; k++)
          place_term(TBL_PRODUCT, PROD_CAP, tbl[TBL_FIRST][k].coef, tbl[TBL_FIRST][k].expo);
        for (int s = 1; s < p; s++) begin
          n = cnt[TBL_PRODUCT];
          for (int k = 0; k < n; k++) tbl[TBL_SCRATCH][k] = tbl[TBL_PRODUCT][k];
          multiply_tables(TBL_SCRATCH, n, TBL_FIRST, cnt[TBL_FIRST]);
        end
      end
    end
    if (none || cnt[TBL_PRODUCT] == 0) begin
      r = '{coef: '0, expo: '0, ovf: ovf_seen, empty: 1'b1, last: 1'b1};
      pending_terms.push_back(r);
    end else begin
      n = cnt[TBL_PRODUCT];
      for (int k = 0; k < n; k++) begin
        r = '{coef: tbl[TBL_PRODUCT][k].coef, expo: tbl[TBL_PRODUCT][k].expo,
              ovf: ovf_seen, empty: 1'b0, last: (k == n - 1)};
        pending_terms.push_back(r);
      end
    end
    cnt[TBL_FIRST] = 0;
    cnt[TBL_SECOND] = 0;
    cnt[TBL_PRODUCT] = 0;
    ovf_seen = 1'b0;
  endfunction

  function automatic void predict_item(logic [1:0] k, logic signed [31:0] c,
                                       logic signed [15:0] e);
    case (k)
      KIND_LOAD_FIRST: begin
        place_term(TBL_FIRST, IN_CAP, c, e);
      end
      KIND_LOAD_SECOND: begin
        place_term(TBL_SECOND, IN_CAP, c, e);
      end
      KIND_COMPUTE: begin
        predict_product();
      end
      default: begin
      end
    endcase
  endfunction

  // Offers one item and returns at the edge where it transfers. Valid stays
  // high on return, so a back-to-back item needs only a new payload.
  task automatic offer_item(logic [1:0] k, logic [31:0] c, logic [15:0] e);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    kind <= k;
    term_coefficient <= c;
    term_exponent <= e;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict_item(k, c, e);
    if (k != KIND_UNUSED) items_sent++;
    if (items_sent >= QUIET_FROM) quiet = 1'b1;
  endtask

  // Register writes happen only with the block idle: every result in, then a
  // short pause for any load still settling.
  task automatic write_reg(logic idx, logic [4:0] data);
    in_valid <= 1'b0;
    while (pending_terms.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_write <= 1'b1;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_IDX_MODE) cur_mode = data[0];
    else cur_power = data;
  endtask

  function automatic logic [31:0] rand_coef();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return 32'($urandom_range(0, 32'h7FFFF)) - 32'h40000;
  endfunction

  // Result side: compares each transfer with the oldest expectation.
  always @(posedge clk) begin
    out_term_t w;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_terms.size() == 0) begin
          $error("result with nothing expected: coef %0h expo %0h",
                 out_coefficient, out_exponent);
          errors++;
        end else begin
          w = pending_terms.pop_front();
          if (out_coefficient !== w.coef) begin
            $error("out_coefficient expected %0h actual %0h", w.coef, out_coefficient);
            errors++;
          end
          if (out_exponent !== w.expo) begin
            $error("out_exponent expected %0h actual %0h", w.expo, out_exponent);
            errors++;
          end
          if (capacity_overflow !== w.ovf) begin
            $error("capacity_overflow expected %0b actual %0b", w.ovf, capacity_overflow);
            errors++;
          end
          if (empty_result !== w.empty) begin
            $error("empty_result expected %0b actual %0b", w.empty, empty_result);
            errors++;
          end
          if (last_term !== w.last) begin
            $error("last_term expected %0b actual %0b", w.last, last_term);
            errors++;
          end
        end
      end
      // Random stall bursts, none once the run is in its quiet tail.
      if (burst_left > 0) burst_left--;
      else if (!quiet && $urandom_range(0, 6) == 0) burst_left = $urandom_range(1, 11);
      out_stall <= hold_long || (burst_left > 0 && !quiet);
    end
  end

  // A long hold-off on the result side, started part way into the random
  // items, so that the block backs up and stalls its input while items are
  // still on offer.
  initial begin
    hold_long = 1'b0;
    wait (items_sent >= HOLD_FROM);
    @(posedge clk);
    hold_long <= 1'b1;
    repeat (600) @(posedge clk);
    hold_long <= 1'b0;
  end

  initial begin
    #40ms;
    $display("sparse_polynomial_multiplier: mismatch");
    $finish;
  end

  initial begin
    stim_row_t rows[$];
    stim_row_t r;
    bit        big;
    int        n1;
    int        n2;
    bit        narrow;
    logic [1:0] k;
    logic [15:0] e;

    errors = 0;
    items_sent = 0;
    quiet = 1'b0;
    burst_left = 0;
    ovf_seen = 1'b0;
    cur_mode = MODE_MULTIPLY;
    cur_power = 5'd2;
    foreach (cnt[i]) cnt[i] = 0;

    // Directed part: empty operands, extremes of the fields, saturated merges,
    // the unused kind, power one, zero and above sixteen, power mode with only
    // the second table loaded.
    r = '{default: '0};
    r.row = ROW_ITEM; r.kind = KIND_COMPUTE; r.typed = 1;
    r.want = '{coef: '0, expo: '0, ovf: 1'b0, empty: 1'b1, last: 1'b1};
    rows.push_back(r);
    r = '{default: '0};
    r.row = ROW_ITEM; r.kind = KIND_LOAD_FIRST; r.coef = 32'h0001_0000; r.expo = 16'h0010;
    rows.push_back(r);
    r.kind = KIND_LOAD_SECOND; r.coef = 32'h0002_0000; r.expo = 16'h0020;
    rows.push_back(r);
    r = '{default: '0};
    r.row = ROW_ITEM; r.kind = KIND_COMPUTE; r.typed = 1;
    r.want = '{coef: 32'h0002_0000, expo: 16'h0030, ovf: 1'b0, empty: 1'b0, last: 1'b1};
    rows.push_back(r);
    r = '{default: '0};
    r.row = ROW_ITEM; r.kind = KIND_UNUSED; r.coef = 32'hFFFF_FFFF; r.expo = 16'hFFFF;
    rows.push_back(r);
    r.kind = KIND_LOAD_FIRST; r.coef = 32'h7FFF_FFFF; r.expo = 16'h7FFF; rows.push_back(r);
    r.kind = KIND_LOAD_FIRST; r.coef = 32'h8000_0000; r.expo = 16'h8000; rows.push_back(r);
    r.kind = KIND_LOAD_SECOND; r.coef = 32'h7FFF_FFFF; r.expo = 16'h7FFF; rows.push_back(r);
    r.kind = KIND_LOAD_SECOND; r.coef = 32'h8000_0000; r.expo = 16'h8000; rows.push_back(r);
    r.kind = KIND_COMPUTE; rows.push_back(r);
    r.kind = KIND_LOAD_FIRST; r.coef = 32'h7FFF_FFFF; r.expo = 16'h0050; rows.push_back(r);
    rows.push_back(r);
    r.kind = KIND_LOAD_SECOND; r.coef = 32'h0001_0000; r.expo = 16'h0000; rows.push_back(r);
    r.kind = KIND_COMPUTE; rows.push_back(r);
    r.kind = KIND_LOAD_SECOND; rows.push_back(r);
    r = '{default: '0};
    r.row = ROW_ITEM; r.kind = KIND_COMPUTE; r.typed = 1;
    r.want = '{coef: '0, expo: '0, ovf: 1'b0, empty: 1'b1, last: 1'b1};
    rows.push_back(r);
    r = '{default: '0};
    r.row = ROW_REG; r.reg_index = CFG_IDX_MODE; r.reg_data = 5'(MODE_POWER); rows.push_back(r);
    r.reg_index = CFG_IDX_POWER; r.reg_data = 5'd1; rows.push_back(r);
    r = '{default: '0};
    r.row = ROW_ITEM; r.kind = KIND_LOAD_FIRST; r.coef = 32'h0003_0000; r.expo = 16'h0020;
    rows.push_back(r);
    r.coef = 32'hFFFF_0000; r.expo = 16'hFFF8; rows.push_back(r);
    r.kind = KIND_COMPUTE; rows.push_back(r);
    r = '{default: '0};
    r.row = ROW_REG; r.reg_index = CFG_IDX_POWER; r.reg_data = 5'd0; rows.push_back(r);
    r = '{default: '0};
    r.row = ROW_ITEM; r.kind = KIND_LOAD_FIRST; r.coef = 32'h0001_0000; r.expo = 16'h0010;
    rows.push_back(r);
    r.kind = KIND_COMPUTE; r.typed = 1;
    r.want = '{coef: 32'h0001_0000, expo: 16'h0010, ovf: 1'b0, empty: 1'b0, last: 1'b1};
    rows.push_back(r);
    r = '{default: '0};
    r.row = ROW_REG; r.reg_index = CFG_IDX_POWER; r.reg_data = 5'd31; rows.push_back(r);
    r = '{default: '0};
    r.row = ROW_ITEM; r.kind = KIND_LOAD_FIRST; r.coef = 32'h0001_0000; r.expo = 16'h0010;
    rows.push_back(r);
    r.kind = KIND_COMPUTE; r.typed = 1;
    r.want = '{coef: 32'h0001_0000, expo: 16'h0100, ovf: 1'b0, empty: 1'b0, last: 1'b1};
    rows.push_back(r);
    r = '{default: '0};
    r.row = ROW_ITEM; r.kind = KIND_LOAD_SECOND; r.coef = 32'h0001_0000; rows.push_back(r);
    r.kind = KIND_COMPUTE; r.coef = '0; r.typed = 1;
    r.want = '{coef: '0, expo: '0, ovf: 1'b0, empty: 1'b1, last: 1'b1};
    rows.push_back(r);
    r = '{default: '0};
    r.row = ROW_REG; r.reg_index = CFG_IDX_MODE; r.reg_data = 5'(MODE_MULTIPLY);
    rows.push_back(r);
    r.reg_index = CFG_IDX_POWER; r.reg_data = 5'd16; rows.push_back(r);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].row == ROW_REG) begin
        write_reg(rows[i].reg_index, rows[i].reg_data);
      end else begin
        offer_item(rows[i].kind, rows[i].coef, rows[i].expo);
        if (rows[i].typed) begin
          void'(pending_terms.pop_back());
          pending_terms.push_back(rows[i].want);
        end
      end
    end

    // Random part: well-formed load sequences closed by a compute, with some
    // empty operands, stray unused kinds and an occasional table overflow.
    while (items_sent < ITEM_TARGET) begin
      big = ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 3) == 0) begin
        write_reg(CFG_IDX_MODE, 5'($urandom_range(0, 1)));
        write_reg(CFG_IDX_POWER, 5'($urandom_range(0, 31)));
      end
      // Keep large powers to small tables so that the run stays short.
      if (big && cur_mode == MODE_POWER && (cur_power == 0 || cur_power > 3))
        write_reg(CFG_IDX_POWER, 5'($urandom_range(1, 3)));
      n1 = big ? $urandom_range(28, 40) : $urandom_range(0, 6);
      n2 = big ? $urandom_range(28, 40) : $urandom_range(0, 6);
      narrow = !big && ($urandom_range(0, 1) == 0);
      while (n1 + n2 > 0) begin
        if ($urandom_range(0, 11) == 0)
          offer_item(KIND_UNUSED, $urandom, 16'($urandom));
        if (n2 == 0 || (n1 > 0 && $urandom_range(0, 1) == 0)) begin
          k = KIND_LOAD_FIRST;
          n1--;
        end else begin
          k = KIND_LOAD_SECOND;
          n2--;
        end
        e = narrow ? 16'($urandom_range(0, 15)) << 2 : 16'($urandom);
        offer_item(k, rand_coef(), e);
      end
      offer_item(KIND_COMPUTE, $urandom, 16'($urandom));
    end

    in_valid <= 1'b0;
    while (pending_terms.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("sparse_polynomial_multiplier: match");
    end else begin
      $display("sparse_polynomial_multiplier: mismatch");
    end
    $finish;
  end

endmodule
